// ===== rtl/kst_pkg.sv =====
// Shared types and constants for the keyed slot table.
// Command and result transaction structs, status, command and grade codes, FSM states.
// No dependencies.
`default_nettype none

package kst_pkg;

	localparam int STAT_BITS   = 7;
	localparam int STAT_FIELDS = 6;
	localparam int STATS_W     = STAT_BITS * STAT_FIELDS;
	localparam int KEY_W       = 16;

	localparam logic [STAT_BITS-1:0] STAT_MAX = 7'd99;

	// Grade thresholds on the sum: six times 20/40/60/80
	localparam logic [9:0] GRADE_C_SUM = 10'd120;
	localparam logic [9:0] GRADE_B_SUM = 10'd240;
	localparam logic [9:0] GRADE_A_SUM = 10'd360;
	localparam logic [9:0] GRADE_S_SUM = 10'd480;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_EDIT   = 2'd3
	} kst_cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_TAKEN     = 3'd3,
		ST_BAD_SLOT  = 3'd4,
		ST_DUP_KEY   = 3'd5,
		ST_BAD_STAT  = 3'd6
	} kst_status_t;

	typedef enum logic [2:0] {
		GRADE_D = 3'd0,
		GRADE_C = 3'd1,
		GRADE_B = 3'd2,
		GRADE_A = 3'd3,
		GRADE_S = 3'd4
	} kst_grade_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_SCAN,
		FSM_DECIDE,
		FSM_SUM
	} kst_state_t;

	typedef struct packed {
		logic [1:0]           command;
		logic [KEY_W-1:0]     key;
		logic [7:0]           slot_choice;
		logic [STAT_BITS-1:0] stat_a;
		logic [STAT_BITS-1:0] stat_b;
		logic [STAT_BITS-1:0] stat_c;
		logic [STAT_BITS-1:0] stat_d;
		logic [STAT_BITS-1:0] stat_e;
		logic [STAT_BITS-1:0] stat_f;
	} kst_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] slot_number;
		logic [7:0] occupied_count;
		logic [9:0] stat_sum;
		logic [2:0] power_grade;
	} kst_result_t;

	typedef struct packed {
		logic       done;
		logic [9:0] sum;
		logic [2:0] grade;
	} kst_sum_res_t;

endpackage

`default_nettype wire

// ===== rtl/kst_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module kst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/kst_sum.sv =====
// Iterative stat summer: one shared adder takes one 7-bit stat per cycle,
// then the grade is read off the sum. Depends on kst_pkg.
`default_nettype none

module kst_sum (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [kst_pkg::STATS_W-1:0] stats,
	output kst_pkg::kst_sum_res_t            res
);

	logic                        run_q;
	logic                        done_q;
	logic [2:0]                  step_q;
	logic [9:0]                  acc_q;
	logic [kst_pkg::STATS_W-1:0] sh_q;
	logic [2:0]                  grade;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'(kst_pkg::STAT_FIELDS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			sh_q  <= stats;
		end else if (run_q) begin
			acc_q <= acc_q + 10'(sh_q[kst_pkg::STAT_BITS-1:0]);
			sh_q  <= sh_q >> kst_pkg::STAT_BITS;
		end
	end

	always_comb begin
		priority if (acc_q < kst_pkg::GRADE_C_SUM) grade = kst_pkg::GRADE_D;
		else if (acc_q < kst_pkg::GRADE_B_SUM) grade = kst_pkg::GRADE_C;
		else if (acc_q < kst_pkg::GRADE_A_SUM) grade = kst_pkg::GRADE_B;
		else if (acc_q < kst_pkg::GRADE_S_SUM) grade = kst_pkg::GRADE_A;
		else grade = kst_pkg::GRADE_S;
	end

	assign res.done  = done_q;
	assign res.sum   = acc_q;
	assign res.grade = grade;

endmodule

`default_nettype wire

// ===== rtl/keyed_slot_table_unit.sv =====
// Keyed slot table top level: sequencer, scan datapath, slot RAM, stat summer.
// Depends on kst_pkg, kst_ram, kst_sum.
`default_nettype none

// Usage:
//  - Command channel: drive item and raise start; the transaction is taken at
//    the edge where start is high and busy is low. busy stays high while the
//    command is worked on.
//  - Result channel: done is high for exactly one cycle with result valid.
//    Every command gives one result; the receiver cannot stall it.
//  - Each command scans every slot through the single RAM read port, one slot
//    per cycle, comparing keys in one shared comparator.
//  - A successful lookup then sums the six stats in a shared adder, one stat
//    per cycle.
//  - busy drops in the cycle the result is shown, so the next command may be
//    taken while done is high.
//  - Reset: after arst_n rises, a clearing pass writes every slot invalid, one
//    slot per cycle, with busy high. The table starts empty.
//  - Keys are compared on their low min(KEY_BITS, 16) bits.

module keyed_slot_table_unit #(
	parameter int SLOT_COUNT = 128,
	parameter int KEY_BITS   = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire kst_pkg::kst_item_t  item,
	output logic                     busy,
	output logic                     done,
	output kst_pkg::kst_result_t     result
);

	localparam int IW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW   = $clog2(SLOT_COUNT + 1);
	localparam int KW   = (KEY_BITS < kst_pkg::KEY_W) ? KEY_BITS : kst_pkg::KEY_W;
	localparam int SW   = kst_pkg::STATS_W;
	localparam int WW   = 1 + KW + SW;
	localparam int CMPW = (IW > 8) ? IW + 2 : 10;

	kst_pkg::kst_state_t state_q, state_d;

	kst_pkg::kst_cmd_t cmd_q;
	logic [KW-1:0]     key_q;
	logic [7:0]        choice_q;
	logic [SW-1:0]     stats_q;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] count_q;
	logic          rd_vld_q;
	logic [IW-1:0] rd_idx_q;

	logic          free_found_q;
	logic [IW-1:0] free_idx_q;
	logic          match_found_q;
	logic [IW-1:0] match_idx_q;
	logic [SW-1:0] match_stats_q;
	logic          taken_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata;
	logic [WW-1:0] ram_rdata;

	logic          w_valid;
	logic [KW-1:0] w_key;
	logic [SW-1:0] w_stats;

	logic            stats_bad;
	logic [CMPW-1:0] choice_m1;
	logic            choice_in_range;
	logic            choice_hit;

	kst_pkg::kst_status_t dec_status;
	logic [IW-1:0]        dec_idx;
	logic                 dec_write;
	logic                 dec_vbit;
	logic [CW-1:0]        count_d;
	logic                 sum_start;

	logic [CW+7:0] slot_ext;
	logic [CW+7:0] count_ext;

	kst_pkg::kst_result_t  result_q;
	logic                  done_q;
	kst_pkg::kst_sum_res_t sum_res;

	kst_ram #(
		.WIDTH(WW),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	kst_sum u_sum (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sum_start),
		.stats (match_stats_q),
		.res   (sum_res)
	);

	assign w_valid = ram_rdata[WW-1];
	assign w_key   = ram_rdata[WW-2 -: KW];
	assign w_stats = ram_rdata[SW-1:0];

	assign choice_m1       = CMPW'(choice_q) - CMPW'(1);
	assign choice_in_range = CMPW'(choice_q) <= CMPW'(SLOT_COUNT);
	assign choice_hit      = choice_m1 == CMPW'(rd_idx_q);

	always_comb begin
		stats_bad = 1'b0;
		for (int j = 0; j < kst_pkg::STAT_FIELDS; j++) begin
			if (stats_q[j*kst_pkg::STAT_BITS +: kst_pkg::STAT_BITS] == '0 ||
			    stats_q[j*kst_pkg::STAT_BITS +: kst_pkg::STAT_BITS] > kst_pkg::STAT_MAX) begin
				stats_bad = 1'b1;
			end
		end
	end

	// Outcome of a command once the scan has finished
	always_comb begin
		dec_status = kst_pkg::ST_OK;
		dec_idx    = match_idx_q;
		dec_write  = 1'b0;
		dec_vbit   = 1'b1;
		count_d    = count_q;
		unique case (cmd_q)
			kst_pkg::CMD_INSERT: begin
				if (choice_q == '0) begin
					dec_idx = free_idx_q;
					if (!free_found_q) dec_status = kst_pkg::ST_FULL;
				end else if (choice_in_range) begin
					dec_idx = choice_m1[IW-1:0];
					if (taken_q) dec_status = kst_pkg::ST_TAKEN;
				end else begin
					dec_status = kst_pkg::ST_BAD_SLOT;
				end
				if (dec_status == kst_pkg::ST_OK && match_found_q) begin
					dec_status = kst_pkg::ST_DUP_KEY;
				end
				if (dec_status == kst_pkg::ST_OK && stats_bad) begin
					dec_status = kst_pkg::ST_BAD_STAT;
				end
				if (dec_status == kst_pkg::ST_OK) begin
					dec_write = 1'b1;
					count_d   = count_q + CW'(1);
				end
			end
			kst_pkg::CMD_DELETE: begin
				if (!match_found_q) begin
					dec_status = kst_pkg::ST_NOT_FOUND;
				end else begin
					dec_write = 1'b1;
					dec_vbit  = 1'b0;
					count_d   = count_q - CW'(1);
				end
			end
			kst_pkg::CMD_LOOKUP: begin
				if (!match_found_q) dec_status = kst_pkg::ST_NOT_FOUND;
			end
			kst_pkg::CMD_EDIT: begin
				if (!match_found_q) begin
					dec_status = kst_pkg::ST_NOT_FOUND;
				end else if (stats_bad) begin
					dec_status = kst_pkg::ST_BAD_STAT;
				end else begin
					dec_write = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kst_pkg::FSM_CLEAR: begin
				if (cnt_q == CW'(SLOT_COUNT - 1)) state_d = kst_pkg::FSM_IDLE;
			end
			kst_pkg::FSM_IDLE: begin
				if (start) state_d = kst_pkg::FSM_SCAN;
			end
			kst_pkg::FSM_SCAN: begin
				if (cnt_q == CW'(SLOT_COUNT)) state_d = kst_pkg::FSM_DECIDE;
			end
			kst_pkg::FSM_DECIDE: begin
				if (cmd_q == kst_pkg::CMD_LOOKUP && match_found_q) begin
					state_d = kst_pkg::FSM_SUM;
				end else begin
					state_d = kst_pkg::FSM_IDLE;
				end
			end
			kst_pkg::FSM_SUM: begin
				if (sum_res.done) state_d = kst_pkg::FSM_IDLE;
			end
			default: state_d = kst_pkg::FSM_CLEAR;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[IW-1:0];
		ram_wdata = '0;
		sum_start = 1'b0;
		busy      = 1'b1;
		unique case (state_q)
			kst_pkg::FSM_CLEAR: begin
				ram_we = 1'b1;
			end
			kst_pkg::FSM_IDLE: begin
				busy = 1'b0;
			end
			kst_pkg::FSM_SCAN: ;
			kst_pkg::FSM_DECIDE: begin
				ram_we    = dec_write;
				ram_waddr = dec_idx;
				ram_wdata = {dec_vbit, key_q, stats_q};
				sum_start = cmd_q == kst_pkg::CMD_LOOKUP && match_found_q;
			end
			kst_pkg::FSM_SUM: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kst_pkg::FSM_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			count_q       <= '0;
			rd_vld_q      <= 1'b0;
			free_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			taken_q       <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			rd_vld_q <= state_q == kst_pkg::FSM_SCAN && cnt_q < CW'(SLOT_COUNT);
			unique case (state_q)
				kst_pkg::FSM_CLEAR: begin
					cnt_q <= (cnt_q == CW'(SLOT_COUNT - 1)) ? '0 : cnt_q + CW'(1);
				end
				kst_pkg::FSM_IDLE: begin
					cnt_q         <= '0;
					free_found_q  <= 1'b0;
					match_found_q <= 1'b0;
					taken_q       <= 1'b0;
				end
				kst_pkg::FSM_SCAN: begin
					if (cnt_q < CW'(SLOT_COUNT)) cnt_q <= cnt_q + CW'(1);
					// rdata belongs to the slot addressed in the previous cycle
					if (rd_vld_q) begin
						if (!w_valid && !free_found_q) free_found_q <= 1'b1;
						if (w_valid && w_key == key_q && !match_found_q) begin
							match_found_q <= 1'b1;
						end
						if (choice_hit) taken_q <= w_valid;
					end
				end
				kst_pkg::FSM_DECIDE: begin
					count_q <= count_d;
					if (!sum_start) done_q <= 1'b1;
				end
				kst_pkg::FSM_SUM: begin
					if (sum_res.done) done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign slot_ext  = {8'd0, CW'(dec_idx) + CW'(1)};
	assign count_ext = {8'd0, count_d};

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == kst_pkg::FSM_IDLE && start) begin
			cmd_q    <= kst_pkg::kst_cmd_t'(item.command);
			key_q    <= item.key[KW-1:0];
			choice_q <= item.slot_choice;
			stats_q  <= {item.stat_f, item.stat_e, item.stat_d,
			             item.stat_c, item.stat_b, item.stat_a};
		end
		rd_idx_q <= cnt_q[IW-1:0];
		if (state_q == kst_pkg::FSM_SCAN && rd_vld_q) begin
			if (!w_valid && !free_found_q) free_idx_q <= rd_idx_q;
			if (w_valid && w_key == key_q && !match_found_q) begin
				match_idx_q   <= rd_idx_q;
				match_stats_q <= w_stats;
			end
		end
		if (state_q == kst_pkg::FSM_DECIDE) begin
			result_q.status         <= dec_status;
			result_q.slot_number    <= (dec_status == kst_pkg::ST_OK) ? slot_ext[7:0] : 8'd0;
			result_q.occupied_count <= count_ext[7:0];
			result_q.stat_sum       <= '0;
			result_q.power_grade    <= '0;
		end else if (state_q == kst_pkg::FSM_SUM && sum_res.done) begin
			result_q.stat_sum    <= sum_res.sum;
			result_q.power_grade <= sum_res.grade;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// A failed command never reports a slot
	a_fail_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != kst_pkg::ST_OK |-> result.slot_number == 8'd0)
		else $error("failed command reports a slot");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOT_COUNT))
		else $error("occupied count above table size");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted command did not raise busy");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == kst_pkg::FSM_DECIDE || state_q == kst_pkg::FSM_SUM))
		else $error("result strobe outside decide or sum");

endmodule

`default_nettype wire
